// ----- hdl/pic_pkg.sv -----
// ============================================================================
// pic_pkg: shared types and constants for the point-in-contour block
// Field widths, command and register codes, the CORDIC arctangent table and
// the structs that carry beats and pipeline stages between modules.
// ============================================================================
package pic_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 28;
    localparam int EDGE_W     = 12;
    localparam int THR_W      = 10;
    localparam int THR_FRAC_W = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // CORDIC datapath: the difference vector is scaled up by GUARD_BITS
    // before rotation, and the angle accumulates in 2^-32 turn units.
    localparam int GUARD_BITS = 24;
    localparam int CORDIC_W   = 48;
    localparam int TURN_W     = 32;
    localparam int TABLE_LEN  = 24;

    localparam int MAX_VERTICES    = 4096;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int CORDIC_ITER_DEF = 16;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    localparam logic [CNT_W-1:0] STRIDE_RESET = 13'd1;
    localparam logic [THR_W-1:0] THR_RESET    = 10'd256;

    localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [TURN_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [CNT_W-1:0]          vertex_count;
    } pic_in_t;

    typedef struct packed {
        logic                    inside_res;
        logic signed [SUM_W-1:0] winding_sum;
        logic [EDGE_W-1:0]       edges_summed;
    } pic_out_t;

    // What travels with each beat down the pipeline.
    typedef struct packed {
        logic valid;
        logic start;
        logic sample;
        logic first;
        logic emit;
        logic zero;
    } pic_tag_t;

    typedef struct packed {
        pic_tag_t                   tag;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [TURN_W-1:0]          z;
    } pic_vec_t;

endpackage

// ----- hdl/pic_ctrl.sv -----
// ============================================================================
// pic_ctrl: contour sequencing at the input
// Holds the query point and the vertex counters, decides for each beat
// whether it is sampled, first or last, and forms the difference vector.
// ============================================================================
module pic_ctrl
    import pic_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     accept,
    input  pic_in_t                  item,
    input  logic [CNT_W-1:0]         stride,
    output pic_tag_t                 tag,
    output logic signed [DIFF_W-1:0] dx,
    output logic signed [DIFF_W-1:0] dy
);

    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] qy_reg, qy_next;
    logic [CNT_W-1:0]          exp_reg, exp_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          phase_reg, phase_next;
    logic [CNT_W-1:0]          eff_reg, eff_next;
    pic_tag_t                  tag_reg, tag_next;
    logic signed [DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [DIFF_W-1:0]  dy_reg, dy_next;
    logic [CNT_W-1:0]          cnt_clamp;
    logic [CNT_W-1:0]          idx_inc;
    logic [CNT_W-1:0]          phase_inc;
    logic                      active;

    always_comb
    begin
        cnt_clamp = (item.vertex_count > CNT_W'(MAX_VERTICES)) ?
                    CNT_W'(MAX_VERTICES) : item.vertex_count;
        active    = (idx_reg < exp_reg);
        idx_inc   = idx_reg + CNT_W'(1);
        phase_inc = phase_reg + CNT_W'(1);

        qx_next    = qx_reg;
        qy_next    = qy_reg;
        exp_next   = exp_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        eff_next   = eff_reg;
        tag_next   = '0;
        dx_next    = {item.coord_x[COORD_W-1], item.coord_x} - {qx_reg[COORD_W-1], qx_reg};
        dy_next    = {item.coord_y[COORD_W-1], item.coord_y} - {qy_reg[COORD_W-1], qy_reg};

        if (accept)
        begin
            case (item.command)
                CMD_START:
                begin
                    qx_next    = item.coord_x;
                    qy_next    = item.coord_y;
                    exp_next   = cnt_clamp;
                    idx_next   = '0;
                    phase_next = '0;
                    eff_next   = (stride == '0 || cnt_clamp < stride) ? CNT_W'(1) : stride;
                    tag_next.valid = 1'b1;
                    tag_next.start = 1'b1;
                    tag_next.emit  = (cnt_clamp == '0);
                end
                CMD_VERTEX:
                begin
                    // A vertex outside any contour is dropped here.
                    if (active)
                    begin
                        tag_next.valid  = 1'b1;
                        tag_next.sample = (phase_reg == '0);
                        tag_next.first  = (idx_reg == '0);
                        tag_next.emit   = (idx_inc == exp_reg);
                        idx_next        = idx_inc;
                        phase_next      = (phase_inc == eff_reg) ? '0 : phase_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg    <= '0;
            qy_reg    <= '0;
            exp_reg   <= '0;
            idx_reg   <= '0;
            phase_reg <= '0;
            eff_reg   <= CNT_W'(1);
            tag_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
        end
        else
        begin
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            exp_reg   <= exp_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            eff_reg   <= eff_next;
            if (advance)
            begin
                tag_reg <= tag_next;
                dx_reg  <= dx_next;
                dy_reg  <= dy_next;
            end
        end
    end

    assign tag = tag_reg;
    assign dx  = dx_reg;
    assign dy  = dy_reg;

    // An empty contour must report on its start beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.command == CMD_START && item.vertex_count == '0)
        |=> (tag_reg.valid && tag_reg.emit))
        else $error("empty contour start did not request a result");

endmodule

// ----- hdl/pic_cell.sv -----
// ============================================================================
// pic_cell: one CORDIC vectoring step
// Rotates the vector by +/- atan(2^-STAGE) toward the x axis, accumulates
// the angle, and passes the result to the next cell through a register.
// ============================================================================
module pic_cell
    import pic_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  pic_vec_t vec_in,
    output pic_vec_t vec_out
);

    localparam logic [TURN_W-1:0] ATAN_STEP = ATAN_TURNS[STAGE];

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    pic_vec_t                   vec_reg, vec_next;

    always_comb
    begin
        xs       = $signed(vec_in.x) >>> STAGE;
        ys       = $signed(vec_in.y) >>> STAGE;
        vec_next = vec_in;
        if (!vec_in.y[CORDIC_W-1])
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + ATAN_STEP;
        end
        else
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else if (advance)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

// ----- hdl/pic_accum.sv -----
// ============================================================================
// pic_accum: angle rounding and winding accumulation
// Rounds the CORDIC angle to ANGLE_BITS, wraps the difference to the
// previous sample and adds it to the saturating winding sum.
// ============================================================================
module pic_accum
    import pic_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  pic_vec_t                vec_in,
    output logic                    emit,
    output logic signed [SUM_W-1:0] sum,
    output logic [EDGE_W-1:0]       edges
);

    localparam int SUMX_W = SUM_W + 1;

    logic [TURN_W-1:0]         z_round;
    pic_tag_t                  rtag_reg;
    logic [ANGLE_BITS-1:0]     ang_reg, ang_next;
    logic [ANGLE_BITS-1:0]     prev_reg, prev_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [EDGE_W-1:0]         edge_reg, edge_next;
    logic                      emit_reg, emit_next;
    logic signed [ANGLE_BITS-1:0] diff;
    logic signed [SUMX_W-1:0]  sum_wide;

    // Round half up to ANGLE_BITS; a zero-length vector has angle zero.
    always_comb
    begin
        z_round  = vec_in.z + (TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS));
        ang_next = vec_in.tag.zero ? '0 : z_round[TURN_W-1 -: ANGLE_BITS];
    end

    always_comb
    begin
        // Wrapping into the signed range makes an exact half turn negative.
        diff      = $signed(ang_reg - prev_reg);
        sum_wide  = $signed({sum_reg[SUM_W-1], sum_reg}) + SUMX_W'(diff);
        prev_next = prev_reg;
        sum_next  = sum_reg;
        edge_next = edge_reg;
        emit_next = rtag_reg.valid && rtag_reg.emit;

        if (rtag_reg.valid)
        begin
            if (rtag_reg.start)
            begin
                prev_next = '0;
                sum_next  = '0;
                edge_next = '0;
            end
            else if (rtag_reg.sample)
            begin
                prev_next = ang_reg;
                if (!rtag_reg.first)
                begin
                    if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    begin
                        sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                   : {1'b0, {(SUM_W-1){1'b1}}};
                    end
                    else
                    begin
                        sum_next = sum_wide[SUM_W-1:0];
                    end
                    if (edge_reg != '1)
                    begin
                        edge_next = edge_reg + EDGE_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtag_reg <= '0;
            ang_reg  <= '0;
            prev_reg <= '0;
            sum_reg  <= '0;
            edge_reg <= '0;
            emit_reg <= 1'b0;
        end
        else if (advance)
        begin
            rtag_reg <= vec_in.tag;
            ang_reg  <= ang_next;
            prev_reg <= prev_next;
            sum_reg  <= sum_next;
            edge_reg <= edge_next;
            emit_reg <= emit_next;
        end
    end

    assign emit  = emit_reg;
    assign sum   = sum_reg;
    assign edges = edge_reg;

    // The edge count only steps by one or restarts from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_reg != $past(edge_reg))
        |-> (edge_reg == '0 || edge_reg == $past(edge_reg) + EDGE_W'(1)))
        else $error("edge count jumped");

endmodule

// ----- hdl/point_in_contour_winding_angle.sv -----
// ============================================================================
// point_in_contour_winding_angle: streaming point-in-contour test
// Sums wrapped angle differences of sampled contour vertices about a query
// point and reports inside when the sum reaches a threshold.
// ============================================================================
// A start beat (command 0) loads the query point and the vertex count;
// vertex beats (command 1) follow. The block accepts one beat per clock
// cycle while item_ready is high, for starts and vertices alike. Each beat
// goes through a control register, a pre-rotation stage, a row of
// CORDIC_ITERATIONS vectoring cells, a rounding stage and the accumulator,
// and a contour's result is then held in the output register. The only stall
// comes from the output register: when a result waits there untaken and the
// next finished result reaches the accumulator, the whole row holds and
// item_ready drops. Configuration (stride and threshold_scale) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. A count of zero
// reports at once with an empty sum; vertex beats outside a contour are
// dropped without a result, and a new start abandons the contour in progress.
module point_in_contour_winding_angle
    import pic_pkg::*;
#(
    parameter int ANGLE_BITS        = ANGLE_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  pic_in_t               item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pic_out_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = SUM_W + THR_FRAC_W;

    // Configuration registers.
    logic [CNT_W-1:0] stride_reg;
    logic [THR_W-1:0] thr_reg;

    // Handshake and pipeline control.
    logic advance;
    logic accept;
    logic out_free;

    // Stage signals.
    pic_tag_t                 ctrl_tag;
    logic signed [DIFF_W-1:0] ctrl_dx;
    logic signed [DIFF_W-1:0] ctrl_dy;
    logic signed [CORDIC_W-1:0] xe;
    logic signed [CORDIC_W-1:0] ye;
    pic_vec_t                 rot_reg, rot_next;
    pic_vec_t                 cell_out [CORDIC_ITERATIONS];

    logic                     acc_emit;
    logic signed [SUM_W-1:0]  acc_sum;
    logic [EDGE_W-1:0]        acc_edges;

    // Output register.
    logic                     result_valid_reg, result_valid_next;
    pic_out_t                 result_reg, result_next;
    logic [SUM_W-1:0]         mag;
    logic [CMP_W-1:0]         lhs;
    logic [CMP_W-1:0]         rhs;

    // The output register takes a new result when it is empty or being read.
    // Everything upstream moves unless a finished result has nowhere to go.
    assign out_free   = !result_valid_reg || result_ready;
    assign advance    = !acc_emit || out_free;
    assign item_ready = advance;
    assign accept     = item_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            thr_reg    <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STRIDE:    stride_reg <= cfg_data;
                REG_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pic_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .accept  (accept),
        .item    (item),
        .stride  (stride_reg),
        .tag     (ctrl_tag),
        .dx      (ctrl_dx),
        .dy      (ctrl_dy)
    );

    // Pre-rotation: scale up by the guard bits, then turn a vector in the
    // left half plane by a quarter turn so that the CORDIC row converges.
    always_comb
    begin
        xe = {{(CORDIC_W - DIFF_W - GUARD_BITS){ctrl_dx[DIFF_W-1]}}, ctrl_dx,
              {GUARD_BITS{1'b0}}};
        ye = {{(CORDIC_W - DIFF_W - GUARD_BITS){ctrl_dy[DIFF_W-1]}}, ctrl_dy,
              {GUARD_BITS{1'b0}}};
        rot_next          = '0;
        rot_next.tag      = ctrl_tag;
        rot_next.tag.zero = (ctrl_dx == '0) && (ctrl_dy == '0);
        rot_next.x        = xe;
        rot_next.y        = ye;
        if (xe[CORDIC_W-1])
        begin
            if (!ye[CORDIC_W-1])
            begin
                rot_next.x = ye;
                rot_next.y = -xe;
                rot_next.z = QUARTER_TURN;
            end
            else
            begin
                rot_next.x = -ye;
                rot_next.y = xe;
                rot_next.z = TURN_W'(0) - QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else if (advance)
        begin
            rot_reg <= rot_next;
        end
    end

    // The CORDIC row: one cell per iteration, each handing its vector on.
    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            pic_cell #(.STAGE(i)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .vec_in  (rot_reg),
                .vec_out (cell_out[i])
            );
        end
        else
        begin : g_body
            pic_cell #(.STAGE(i)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .vec_in  (cell_out[i-1]),
                .vec_out (cell_out[i])
            );
        end
    end

    pic_accum #(.ANGLE_BITS(ANGLE_BITS)) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .vec_in  (cell_out[CORDIC_ITERATIONS-1]),
        .emit    (acc_emit),
        .sum     (acc_sum),
        .edges   (acc_edges)
    );

    // Inside when |sum| * 256 >= threshold_scale * half turn.
    always_comb
    begin
        mag = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
        lhs = {mag, {THR_FRAC_W{1'b0}}};
        rhs = CMP_W'(thr_reg) << (ANGLE_BITS - 1);

        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (out_free)
        begin
            result_valid_next        = acc_emit;
            result_next.inside_res   = (lhs >= rhs);
            result_next.winding_sum  = acc_sum;
            result_next.edges_summed = acc_edges;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Input back-pressure only comes from a result blocked behind another.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (acc_emit && result_valid && !result_ready))
        else $error("input stalled without a blocked result");

    // A new result always comes from the accumulator's emit stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(acc_emit))
        else $error("result appeared without an emit");

endmodule

// ----- test/testbench.sv -----
// ============================================================================
// testbench: self-checking bench for point_in_contour_winding_angle
// Streams query points and contour vertices through the valid/ready input,
// tracks the winding-angle sum with its own CORDIC model of the block, and
// compares every result beat field by field against the predicted verdict.
// ============================================================================
module testbench;
    import pic_pkg::*;

    localparam int     ANG_W         = ANGLE_BITS_DEF;
    localparam longint COORD_HI      = 2 ** (COORD_W - 1) - 1;
    localparam longint COORD_LO      = -(2 ** (COORD_W - 1));
    localparam longint SUM_HI        = 2 ** (SUM_W - 1) - 1;
    localparam longint SUM_LO        = -(2 ** (SUM_W - 1));
    localparam int     EDGE_LIMIT    = 2 ** EDGE_W - 1;
    // The pipeline is CORDIC_ITERATIONS + 5 deep; give it some slack on top.
    localparam int     SETTLE_CYCLES = CORDIC_ITER_DEF + 12;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    pic_in_t               item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    pic_out_t              result;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_STRIDE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Shadow copy of the configuration registers.
    logic [CNT_W-1:0] cfg_stride = STRIDE_RESET;
    logic [THR_W-1:0] cfg_thresh = THR_RESET;

    // Shadow copy of the contour tracking state.
    longint           qpt_x;
    longint           qpt_y;
    int unsigned      contour_len;
    int unsigned      vert_idx;
    int unsigned      step_eff = 1;
    logic [ANG_W-1:0] last_bearing;
    longint           turn_sum;
    int unsigned      edge_cnt;

    pic_out_t    pending_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned beats_sent     = 0;
    bit          idle_on        = 1'b1;

    point_in_contour_winding_angle dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // The sink stalls about a quarter of the time unless idling is switched
    // off for the current stretch of traffic.
    always @(posedge clk)
        result_ready <= idle_on ? ($urandom_range(0, 99) >= 26) : 1'b1;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Builds the verdict for the contour that just closed and queues it.
    function automatic void queue_verdict();
        pic_out_t verdict;
        longint   mag;
        mag = (turn_sum < 0) ? -turn_sum : turn_sum;
        verdict.inside_res   = (mag <<< THR_FRAC_W) >= (longint'(cfg_thresh) <<< (ANG_W - 1));
        verdict.winding_sum  = turn_sum[SUM_W-1:0];
        verdict.edges_summed = edge_cnt[EDGE_W-1:0];
        pending_verdicts = {pending_verdicts, verdict};
    endfunction

    // Advances the shadow state by one accepted input beat. Sampled vertices
    // are turned into an angle about the query point with the same vectoring
    // CORDIC as the block: 2^-32 turn accumulator, rounded half up.
    function automatic void follow_contour(input pic_in_t b);
        int unsigned      n;
        longint           x;
        longint           y;
        longint           xs;
        longint           ys;
        longint           t;
        logic [TURN_W-1:0] z;
        logic [ANG_W-1:0] ang;
        logic [ANG_W-1:0] delta;
        if (b.command == CMD_START)
        begin
            n = b.vertex_count;
            if (n > MAX_VERTICES)
                n = MAX_VERTICES;
            qpt_x        = b.coord_x;
            qpt_y        = b.coord_y;
            contour_len  = n;
            vert_idx     = 0;
            step_eff     = (cfg_stride == 0 || n < cfg_stride) ? 1 : cfg_stride;
            last_bearing = '0;
            turn_sum     = 0;
            edge_cnt     = 0;
            if (n == 0)
                queue_verdict();
            return;
        end
        // Vertices with no open contour are dropped.
        if (vert_idx >= contour_len)
            return;
        if (vert_idx % step_eff == 0)
        begin
            x = longint'(b.coord_x) - qpt_x;
            y = longint'(b.coord_y) - qpt_y;
            z = '0;
            if (x == 0 && y == 0)
                ang = '0;
            else
            begin
                x = x <<< GUARD_BITS;
                y = y <<< GUARD_BITS;
                // Fold the left half plane onto the right one first.
                if (x < 0)
                begin
                    if (y >= 0)
                    begin
                        t = x;
                        x = y;
                        y = -t;
                        z = z + QUARTER_TURN;
                    end
                    else
                    begin
                        t = x;
                        x = -y;
                        y = t;
                        z = z - QUARTER_TURN;
                    end
                end
                for (int i = 0; i < CORDIC_ITER_DEF && i < TABLE_LEN; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_TURNS[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_TURNS[i];
                    end
                end
                z   = z + (32'd1 << (TURN_W - 1 - ANG_W));
                ang = z[TURN_W-1 -: ANG_W];
            end
            if (vert_idx != 0)
            begin
                // Modular difference read as signed: an exact half turn
                // lands on the negative side.
                delta    = ang - last_bearing;
                turn_sum = turn_sum + longint'($signed(delta));
                if (turn_sum > SUM_HI)
                    turn_sum = SUM_HI;
                if (turn_sum < SUM_LO)
                    turn_sum = SUM_LO;
                if (edge_cnt < EDGE_LIMIT)
                    edge_cnt++;
            end
            last_bearing = ang;
        end
        vert_idx++;
        if (vert_idx == contour_len)
            queue_verdict();
    endfunction

    function automatic pic_in_t make_beat(input logic cmd, input longint x, input longint y,
                                          input int unsigned cnt);
        pic_in_t b;
        if (x > COORD_HI) x = COORD_HI;
        if (x < COORD_LO) x = COORD_LO;
        if (y > COORD_HI) y = COORD_HI;
        if (y < COORD_LO) y = COORD_LO;
        b.command      = cmd;
        b.coord_x      = x[COORD_W-1:0];
        b.coord_y      = y[COORD_W-1:0];
        b.vertex_count = cnt[CNT_W-1:0];
        return b;
    endfunction

    function automatic longint rand_coord();
        return longint'($urandom_range(0, 2 ** COORD_W - 1)) + COORD_LO;
    endfunction

    // Presents one beat and holds it until the block takes it. Random idle
    // cycles go in front of the beat while idling is on; valid stays high back to back otherwise.
    task automatic send_beat(input pic_in_t b);
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item       <= b;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        follow_contour(b);
        beats_sent++;
    endtask

    // Stops sending and lets every outstanding verdict come back. Beats that
    // produce no verdict may still be in flight, so the pipeline gets a few
    // extra cycles to empty as well.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STRIDE)
            cfg_stride = val[CNT_W-1:0];
        else
            cfg_thresh = val[THR_W-1:0];
    endtask

    // Sends a start beat and then walks a square of half side `half` centred
    // on (cx, cy), `turns` times round, with a little jitter on each vertex.
    // With the centre near the query point the walk winds round it; with the
    // centre far away the angle swings back and forth and nets to about zero.
    task automatic send_loop_contour(input longint qx, input longint qy, input longint cx,
                                     input longint cy, input longint half,
                                     input int unsigned cnt, input int unsigned turns,
                                     input bit ccw);
        int unsigned n;
        longint      perim;
        longint      p;
        longint      px;
        longint      py;
        n     = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
        perim = 8 * half;
        send_beat(make_beat(CMD_START, qx, qy, cnt));
        for (int unsigned k = 0; k < n; k++)
        begin
            p = (longint'(k) * turns * perim / n) % perim;
            if (p < 2 * half)
            begin
                px = half;
                py = p - half;
            end
            else if (p < 4 * half)
            begin
                px = 3 * half - p;
                py = half;
            end
            else if (p < 6 * half)
            begin
                px = -half;
                py = 5 * half - p;
            end
            else
            begin
                px = p - 7 * half;
                py = -half;
            end
            if (!ccw)
                py = -py;
            send_beat(make_beat(CMD_VERTEX, cx + px + longint'($urandom_range(0, 16)) - 8,
                                cy + py + longint'($urandom_range(0, 16)) - 8, $urandom));
        end
    endtask

    // Short contours, the coordinate extremes, a zero-length vector, an exact
    // half-turn swing, a vertex with no open contour, and a restart.
    task automatic test_special_cases();
        // Empty contour: the verdict follows the start beat itself.
        send_beat(make_beat(CMD_START, COORD_HI, COORD_HI, 0));
        // One vertex: nothing to difference.
        send_beat(make_beat(CMD_START, COORD_LO, COORD_LO, 1));
        send_beat(make_beat(CMD_VERTEX, COORD_HI, COORD_HI, 0));
        // Compass points at the range limits, closing on the query point
        // itself, whose angle is taken as zero.
        send_beat(make_beat(CMD_START, 0, 0, 5));
        send_beat(make_beat(CMD_VERTEX, COORD_HI, 0, 0));
        send_beat(make_beat(CMD_VERTEX, 0, COORD_HI, 0));
        send_beat(make_beat(CMD_VERTEX, COORD_LO, 0, 0));
        send_beat(make_beat(CMD_VERTEX, 0, COORD_LO, 0));
        send_beat(make_beat(CMD_VERTEX, 0, 0, 0));
        // Straight across the query point and back: two exact half turns.
        send_beat(make_beat(CMD_START, 100, -50, 3));
        send_beat(make_beat(CMD_VERTEX, 101, -50, 0));
        send_beat(make_beat(CMD_VERTEX, 99, -50, 0));
        send_beat(make_beat(CMD_VERTEX, 101, -50, 0));
        // No contour is open now, so this vertex is dropped.
        send_beat(make_beat(CMD_VERTEX, COORD_LO, COORD_HI, 2 ** CNT_W - 1));
        // The first contour is abandoned by the second start.
        send_beat(make_beat(CMD_START, 0, 0, 6));
        send_beat(make_beat(CMD_VERTEX, 10, 0, 0));
        send_beat(make_beat(CMD_VERTEX, 0, 10, 0));
        send_beat(make_beat(CMD_START, 5, 5, 2));
        send_beat(make_beat(CMD_VERTEX, COORD_HI, COORD_LO, 0));
        send_beat(make_beat(CMD_VERTEX, COORD_LO, COORD_HI, 0));
    endtask

    task automatic test_register_extremes();
        // A zero threshold makes even empty contours inside.
        write_reg(REG_THRESHOLD, 0);
        send_beat(make_beat(CMD_START, -7, 3, 0));
        send_beat(make_beat(CMD_START, 1, 1, 1));
        send_beat(make_beat(CMD_VERTEX, 40, -40, 0));
        // Top threshold: four windings clear it, one does not.
        write_reg(REG_THRESHOLD, 2 ** THR_W - 1);
        send_loop_contour(0, 0, 30, -20, 5000, 64, 4, 1'b1);
        send_loop_contour(-3000, 2000, -3000, 2000, 800, 40, 1, 1'b0);
        // Data bits above the register width are dropped.
        write_reg(REG_THRESHOLD, 2 ** CFG_DATA_W - 1);
        send_loop_contour(0, 0, 0, 0, 100, 30, 2, 1'b0);
        // A zero stride, and strides larger than the count, fall back to one.
        write_reg(REG_STRIDE, 0);
        write_reg(REG_THRESHOLD, THR_RESET);
        send_loop_contour(1000, 1000, 1000, 1000, 700, 40, 1, 1'b1);
        write_reg(REG_STRIDE, MAX_VERTICES);
        send_loop_contour(0, 0, 10, 10, 300, 12, 1, 1'b0);
        write_reg(REG_STRIDE, 2 ** CNT_W - 1);
        send_loop_contour(0, 0, 10, 10, 300, 12, 1, 1'b1);
        // A stride of three with a count of exactly three samples one vertex.
        write_reg(REG_STRIDE, 3);
        send_loop_contour(-500, 500, -500, 500, 2000, 40, 1, 1'b1);
        send_loop_contour(0, 0, 0, 0, 50, 3, 1, 1'b0);
        write_reg(REG_STRIDE, STRIDE_RESET);
    endtask

    task automatic test_long_contours();
        // A count beyond the maximum is clamped; the contour stays open and
        // the start of the next one abandons it.
        send_beat(make_beat(CMD_START, 1000, -2000, 2 ** CNT_W - 1));
        repeat (8)
            send_beat(make_beat(CMD_VERTEX, rand_coord(), rand_coord(), $urandom));
        // A longer contour with every vertex sampled, three windings.
        send_loop_contour(1000, -2000, 0, 0, 200000, 400, 3, 1'b0);
    endtask

    // Mostly well-formed contours with random geometry, mixed with stray
    // vertices, truncated contours and restarts. The middle phase runs with
    // no idling on either side.
    task automatic test_random_traffic();
        int unsigned phase_base;
        int unsigned kind;
        int unsigned n;
        int unsigned m;
        longint      qx;
        longint      qy;
        longint      half;
        longint      cx;
        longint      cy;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_STRIDE, (phase == 4) ? $urandom_range(0, 2 ** CNT_W - 1)
                                               : $urandom_range(1, 4));
            write_reg(REG_THRESHOLD, (phase == 1) ? $urandom_range(0, 2 ** THR_W - 1)
                                                  : $urandom_range(128, 384));
            idle_on    = (phase != 2);
            phase_base = beats_sent;
            while (beats_sent - phase_base < 155)
            begin
                kind = $urandom_range(0, 99);
                qx   = longint'($urandom_range(0, 600000)) - 300000;
                qy   = longint'($urandom_range(0, 600000)) - 300000;
                m    = $urandom_range(0, 99);
                n    = (m < 6) ? $urandom_range(0, 1)
                     : (m < 12) ? $urandom_range(25, 200) : $urandom_range(2, 24);
                if (kind < 50)
                begin
                    half = $urandom_range(50, 100000);
                    cx   = qx;
                    cy   = qy;
                    if ($urandom_range(0, 1))
                    begin
                        cx = cx + longint'($urandom_range(0, half / 2)) - half / 4;
                        cy = cy + longint'($urandom_range(0, half / 2)) - half / 4;
                    end
                    else
                    begin
                        cx = cx + ($urandom_range(0, 1) ? 1 : -1) * (2 * half
                                  + longint'($urandom_range(0, half)));
                        cy = cy + longint'($urandom_range(0, 2 * half)) - half;
                    end
                    send_loop_contour(qx, qy, cx, cy, half, n,
                                      ($urandom_range(0, 3) == 0) ? 2 : 1, $urandom_range(0, 1));
                end
                else if (kind < 70)
                begin
                    // Scattered vertices, either near the query point or
                    // anywhere in the coordinate range.
                    m = $urandom_range(0, 1);
                    if (m == 0)
                    begin
                        qx = rand_coord();
                        qy = rand_coord();
                    end
                    send_beat(make_beat(CMD_START, qx, qy, n));
                    for (int unsigned k = 0; k < n; k++)
                    begin
                        if (m == 0)
                            send_beat(make_beat(CMD_VERTEX, rand_coord(), rand_coord(),
                                                $urandom));
                        else
                            send_beat(make_beat(CMD_VERTEX,
                                                qx + longint'($urandom_range(0, 4000)) - 2000,
                                                qy + longint'($urandom_range(0, 4000)) - 2000,
                                                $urandom));
                    end
                end
                else if (kind < 80)
                begin
                    repeat ($urandom_range(1, 3))
                        send_beat(make_beat(CMD_VERTEX, rand_coord(), rand_coord(), $urandom));
                end
                else if (kind < 97)
                begin
                    // Start with any count, then only a few vertices; the
                    // next start usually abandons it.
                    send_beat(make_beat(CMD_START, rand_coord(), rand_coord(),
                                        $urandom_range(0, 2 ** CNT_W - 1)));
                    repeat ($urandom_range(0, 3))
                        send_beat(make_beat(CMD_VERTEX, rand_coord(), rand_coord(), $urandom));
                end
                else
                    wait_drained();
            end
            // Close the phase on a complete contour so nothing stays open
            // across the register writes.
            send_loop_contour(qx, qy, qx, qy, 400, $urandom_range(2, 12), 1, 1'b1);
        end
        idle_on = 1'b1;
    endtask

    // Every accepted result beat is matched against the oldest verdict.
    always @(posedge clk)
    begin
        pic_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
                flag_mismatch("result beat with no verdict pending");
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.inside_res !== want.inside_res)
                    flag_mismatch($sformatf("inside_res %0b, predicted %0b",
                                            result.inside_res, want.inside_res));
                if (result.winding_sum !== want.winding_sum)
                    flag_mismatch($sformatf("winding_sum %0d, predicted %0d",
                                            result.winding_sum, want.winding_sum));
                if (result.edges_summed !== want.edges_summed)
                    flag_mismatch($sformatf("edges_summed %0d, predicted %0d",
                                            result.edges_summed, want.edges_summed));
            end
        end
    end

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_register_extremes();
        test_long_contours();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
